/* src/lsag_pkg.sv */
package lsag_pkg;

  localparam int DEF_INDEX_BITS = 24;
  localparam int DEF_PASS_BITS  = 24;

  localparam int POS_PORT_BITS  = 25;
  localparam int PASS_PORT_BITS = 24;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int MODE_BITS      = 2;
  localparam int STRIDE_BITS    = 5;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [MODE_BITS-1:0] LOOP_NONE     = 2'd0;
  localparam logic [MODE_BITS-1:0] LOOP_JUMP     = 2'd1;
  localparam logic [MODE_BITS-1:0] LOOP_PINGPONG = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_MODE      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_FIRST     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_LAST      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_STRIDE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_VALUES    = 3'd4;

  typedef struct packed {
    logic [MODE_BITS-1:0]     loop_mode;
    logic [CFG_DATA_BITS-1:0] loop_first;
    logic [CFG_DATA_BITS-1:0] loop_last;
    logic [STRIDE_BITS-1:0]   channel_stride;
    logic [CFG_DATA_BITS-1:0] wave_values;
  } cfg_t;

  typedef struct packed {
    logic                             opcode;
    logic signed [POS_PORT_BITS-1:0]  start_position;
    logic                             start_backward;
    logic [PASS_PORT_BITS-1:0]        start_passes;
  } item_t;

  typedef struct packed {
    logic signed [POS_PORT_BITS-1:0]  sample_position;
    logic                             inside_wave;
    logic [PASS_PORT_BITS-1:0]        passes_left;
  } result_t;

endpackage

/* src/lsag_cfg.sv */
module lsag_cfg
  import lsag_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_mode      <= LOOP_NONE;
      cfg.loop_first     <= '0;
      cfg.loop_last      <= '0;
      cfg.channel_stride <= STRIDE_BITS'(1);
      cfg.wave_values    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOOP_MODE:      cfg.loop_mode      <= cfg_data[MODE_BITS-1:0];
        REG_LOOP_FIRST:     cfg.loop_first     <= cfg_data;
        REG_LOOP_LAST:      cfg.loop_last      <= cfg_data;
        REG_CHANNEL_STRIDE: cfg.channel_stride <= cfg_data[STRIDE_BITS-1:0];
        REG_WAVE_VALUES:    cfg.wave_values    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/lsag_core.sv */
module lsag_core
  import lsag_pkg::*;
#(
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  parameter int PASS_BITS  = DEF_PASS_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    take,
  input  item_t   item,
  output result_t result
);

  localparam int POS_BITS = INDEX_BITS + 1;
  localparam int CMP_BITS = (POS_BITS > CFG_DATA_BITS) ? POS_BITS : CFG_DATA_BITS;

  logic signed [POS_BITS-1:0] position, position_next;
  logic                       walking_backward, walking_backward_next;
  logic [PASS_BITS-1:0]       passes_remaining, passes_remaining_next;

  logic signed [POS_BITS-1:0] stride_p, dir, step, first_p, last_p;
  logic                       looping;

  assign result.sample_position = POS_PORT_BITS'(position);
  assign result.inside_wave     = !position[POS_BITS-1] &&
      (CMP_BITS'($unsigned(position)) < CMP_BITS'(cfg.wave_values));
  assign result.passes_left     = PASS_PORT_BITS'(passes_remaining);

  always_comb begin
    stride_p = POS_BITS'(cfg.channel_stride);
    first_p  = POS_BITS'(cfg.loop_first);
    last_p   = POS_BITS'(cfg.loop_last);
    dir      = walking_backward ? -stride_p : stride_p;
    step     = position + dir;
    looping  = (passes_remaining != '0) && (cfg.loop_mode != LOOP_NONE);

    position_next         = position;
    walking_backward_next = walking_backward;
    passes_remaining_next = passes_remaining;

    if (take) begin
      if (item.opcode == OP_LOAD) begin
        position_next         = POS_BITS'(item.start_position);
        walking_backward_next = item.start_backward;
        passes_remaining_next = PASS_BITS'(item.start_passes);
      end else begin
        position_next = step;
        if (looping) begin
          case (cfg.loop_mode) inside
            LOOP_PINGPONG: begin
              if (walking_backward && step == first_p + dir) begin
                passes_remaining_next = passes_remaining - PASS_BITS'(1);
                walking_backward_next = !walking_backward;
                position_next         = first_p - dir;
              end else if (step == last_p + dir) begin
                passes_remaining_next = passes_remaining - PASS_BITS'(1);
                walking_backward_next = !walking_backward;
                position_next         = last_p - dir;
              end
            end
            default: begin
              // jump loop; the unused mode code behaves the same
              if (step == last_p + dir) begin
                passes_remaining_next = passes_remaining - PASS_BITS'(1);
                position_next         = first_p;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= '0;
      walking_backward <= 1'b0;
      passes_remaining <= '0;
    end else begin
      position         <= position_next;
      walking_backward <= walking_backward_next;
      passes_remaining <= passes_remaining_next;
    end
  end

endmodule

/* src/looping_sample_address_generator.sv */
// Channel | Dir | Handshake             | Beat
// in      | in  | in_valid / in_ready   | opcode, start_position, start_backward, start_passes
// out     | out | out_valid / out_ready | sample_position, inside_wave, passes_left
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One input beat per cycle unless an advance beat waits behind a stalled out.
// Input register, step logic, result register; load beats give no output.
// The position update loop closes in the step logic, so back-to-back beats run at full rate.
// Synchronous reset clears state and both valid flags, resets config; cfg_ready is always high.
// A stalled out stalls in only when an advance beat waits behind it.
module looping_sample_address_generator
  import lsag_pkg::*;
#(
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  parameter int PASS_BITS  = DEF_PASS_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic signed [POS_PORT_BITS-1:0]  start_position,
  input  logic                             start_backward,
  input  logic [PASS_PORT_BITS-1:0]        start_passes,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [POS_PORT_BITS-1:0]  sample_position,
  output logic                             inside_wave,
  output logic [PASS_PORT_BITS-1:0]        passes_left,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    take;
  result_t core_result;
  result_t result;

  assign cfg_ready = 1'b1;

  lsag_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign take = item_valid && ((item.opcode == OP_LOAD) || !out_valid || out_ready);
  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.opcode         <= opcode;
      item.start_position <= start_position;
      item.start_backward <= start_backward;
      item.start_passes   <= start_passes;
    end
  end

  lsag_core #(
    .INDEX_BITS (INDEX_BITS),
    .PASS_BITS  (PASS_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .take   (take),
    .item   (item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && item.opcode == OP_ADVANCE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.opcode == OP_ADVANCE) begin
      result <= core_result;
    end
  end

  assign sample_position = result.sample_position;
  assign inside_wave     = result.inside_wave;
  assign passes_left     = result.passes_left;

endmodule

/* src/lsag_checker.sv */
module lsag_props
  import lsag_pkg::*;
(
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [POS_PORT_BITS-1:0]  sample_position,
  input logic                             inside_wave,
  input logic [PASS_PORT_BITS-1:0]        passes_left
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_position) &&
      $stable(inside_wave) && $stable(passes_left))
    else $error("out beat changed while stalled");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  a_inside_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_wave |-> !sample_position[POS_PORT_BITS-1])
    else $error("negative position flagged inside wave");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in stalled without a blocked out beat");

endmodule

bind looping_sample_address_generator lsag_props u_lsag_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .sample_position (sample_position),
  .inside_wave     (inside_wave),
  .passes_left     (passes_left)
);

/* verif/lsag_checker.sv */
`timescale 1ns / 100ps

module lsag_checker
  import lsag_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            opcode,
  input  logic signed [POS_PORT_BITS-1:0] start_position,
  input  logic                            start_backward,
  input  logic [PASS_PORT_BITS-1:0]       start_passes,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic signed [POS_PORT_BITS-1:0] sample_position,
  input  logic                            inside_wave,
  input  logic [PASS_PORT_BITS-1:0]       passes_left,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data,
  output int                              mismatches,
  output int                              outstanding
);

  cfg_t                      cfg;
  logic [POS_PORT_BITS-1:0]  pos;
  logic                      backward;
  logic [PASS_PORT_BITS-1:0] passes;
  result_t                   due_results[$];
  result_t                   want;
  int                        errs;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    errs        = 0;
  end

  // position update after an emitted address; all sums wrap at the port width
  task automatic step_position();
    logic [POS_PORT_BITS-1:0] step;
    logic [POS_PORT_BITS-1:0] nxt;
    logic [POS_PORT_BITS-1:0] first_w;
    logic [POS_PORT_BITS-1:0] last_w;
    step = {{(POS_PORT_BITS-STRIDE_BITS){1'b0}}, cfg.channel_stride};
    if (backward) begin
      step = '0 - step;
    end
    first_w = {1'b0, cfg.loop_first};
    last_w  = {1'b0, cfg.loop_last};
    nxt     = pos + step;
    if (passes != '0 && cfg.loop_mode != LOOP_NONE) begin
      if (cfg.loop_mode == LOOP_PINGPONG) begin
        if (backward && nxt == first_w + step) begin
          passes   = passes - PASS_PORT_BITS'(1);
          backward = !backward;
          nxt      = first_w - step;
        end else if (nxt == last_w + step) begin
          passes   = passes - PASS_PORT_BITS'(1);
          backward = !backward;
          nxt      = last_w - step;
        end
      end else if (nxt == last_w + step) begin
        passes = passes - PASS_PORT_BITS'(1);
        nxt    = first_w;
      end
    end
    pos = nxt;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg                = '0;
      cfg.channel_stride = STRIDE_BITS'(1);
      pos                = '0;
      backward           = 1'b0;
      passes             = '0;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          if (errs < 10) begin
            $display("unexpected beat on out: pos %0d inside %0b passes %0d",
                     sample_position, inside_wave, passes_left);
          end
          errs++;
        end else begin
          want = due_results.pop_front();
          if (want.sample_position !== sample_position ||
              want.inside_wave !== inside_wave ||
              want.passes_left !== passes_left) begin
            if (errs < 10) begin
              $display({"out mismatch: expected pos %0d inside %0b passes %0d,",
                        " got pos %0d inside %0b passes %0d"},
                       $signed(want.sample_position), want.inside_wave, want.passes_left,
                       sample_position, inside_wave, passes_left);
            end
            errs++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOOP_MODE:      cfg.loop_mode      = cfg_data[MODE_BITS-1:0];
          REG_LOOP_FIRST:     cfg.loop_first     = cfg_data;
          REG_LOOP_LAST:      cfg.loop_last      = cfg_data;
          REG_CHANNEL_STRIDE: cfg.channel_stride = cfg_data[STRIDE_BITS-1:0];
          REG_WAVE_VALUES:    cfg.wave_values    = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        if (opcode == OP_LOAD) begin
          pos      = start_position;
          backward = start_backward;
          passes   = start_passes;
        end else begin
          want.sample_position = pos;
          want.inside_wave     = !pos[POS_PORT_BITS-1] &&
                                 (pos[CFG_DATA_BITS-1:0] < cfg.wave_values);
          want.passes_left     = passes;
          due_results.push_back(want);
          step_position();
        end
      end
    end
    outstanding <= due_results.size();
    mismatches  <= errs;
  end

endmodule

/* verif/tb_looping_sample_address_generator.sv */
`timescale 1ns / 100ps

module tb_looping_sample_address_generator;
  import lsag_pkg::*;

  localparam int RANDOM_ITEMS  = 650;
  localparam int PHASE_ITEMS   = 50;
  localparam int CALM_ITEMS    = 120;
  localparam int LONG_HOLD     = 150;
  localparam int DRAIN_CYCLES  = 6;
  localparam int LIMIT_CYCLES  = 200000;
  localparam logic [MODE_BITS-1:0] LOOP_UNUSED = 2'd3;

  logic                            clk            = 1'b0;
  logic                            rst            = 1'b1;
  logic                            in_valid       = 1'b0;
  logic                            in_ready;
  logic                            opcode         = OP_LOAD;
  logic signed [POS_PORT_BITS-1:0] start_position = '0;
  logic                            start_backward = 1'b0;
  logic [PASS_PORT_BITS-1:0]       start_passes   = '0;
  logic                            out_valid;
  logic                            out_ready      = 1'b0;
  logic signed [POS_PORT_BITS-1:0] sample_position;
  logic                            inside_wave;
  logic [PASS_PORT_BITS-1:0]       passes_left;
  logic                            cfg_valid      = 1'b0;
  logic                            cfg_ready;
  logic [CFG_INDEX_BITS-1:0]       cfg_index      = REG_LOOP_MODE;
  logic [CFG_DATA_BITS-1:0]        cfg_data       = '0;
  int                              mismatches;
  int                              outstanding;

  int cycles   = 0;
  int sent     = 0;
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  logic [CFG_DATA_BITS-1:0] first_now;
  logic [CFG_DATA_BITS-1:0] last_now;
  logic [STRIDE_BITS-1:0]   stride_now;

  looping_sample_address_generator u_dut (.*);

  lsag_checker u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // out side: random stall bursts, one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send(logic op, logic [POS_PORT_BITS-1:0] spos, logic back,
                      logic [PASS_PORT_BITS-1:0] npass);
    in_valid       <= 1'b1;
    opcode         <= op;
    start_position <= spos;
    start_backward <= back;
    start_passes   <= npass;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic load(logic [POS_PORT_BITS-1:0] spos, logic back,
                      logic [PASS_PORT_BITS-1:0] npass);
    maybe_gap();
    send(OP_LOAD, spos, back, npass);
  endtask

  // unused payload fields get random bits on advance beats
  task automatic step_once();
    maybe_gap();
    send(OP_ADVANCE, POS_PORT_BITS'($urandom), 1'($urandom_range(0, 1)),
         PASS_PORT_BITS'($urandom));
  endtask

  // let results and any trailing load beat clear the pipe
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(logic [MODE_BITS-1:0] mode, logic [CFG_DATA_BITS-1:0] first,
                            logic [CFG_DATA_BITS-1:0] last, logic [STRIDE_BITS-1:0] stride,
                            logic [CFG_DATA_BITS-1:0] wave);
    write_reg(REG_LOOP_MODE, {{(CFG_DATA_BITS-MODE_BITS){1'b0}}, mode});
    write_reg(REG_LOOP_FIRST, first);
    write_reg(REG_LOOP_LAST, last);
    write_reg(REG_CHANNEL_STRIDE, {{(CFG_DATA_BITS-STRIDE_BITS){1'b0}}, stride});
    write_reg(REG_WAVE_VALUES, wave);
    cfg_valid  <= 1'b0;
    first_now  = first;
    last_now   = last;
    stride_now = stride;
  endtask

  task automatic random_config();
    logic [MODE_BITS-1:0]     mode;
    logic [STRIDE_BITS-1:0]   stride;
    logic [CFG_DATA_BITS-1:0] first;
    logic [CFG_DATA_BITS-1:0] last;
    logic [CFG_DATA_BITS-1:0] wave;
    int r;
    r = $urandom_range(0, 9);
    mode = (r == 0) ? LOOP_NONE : (r == 1) ? LOOP_UNUSED : (r < 6) ? LOOP_JUMP : LOOP_PINGPONG;
    case ($urandom_range(0, 11))
      0:       stride = '0;
      1:       stride = STRIDE_BITS'($urandom_range(17, 31));
      2:       stride = 5'd16;
      default: stride = STRIDE_BITS'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 7))
      0:       last = '1;
      1:       last = '0;
      2:       last = CFG_DATA_BITS'($urandom);
      default: last = CFG_DATA_BITS'($urandom_range(0, 4000));
    endcase
    if ($urandom_range(0, 5) == 0) begin
      first = CFG_DATA_BITS'($urandom);
    end else begin
      first = CFG_DATA_BITS'(last - $urandom_range(0, 8) * stride);
    end
    case ($urandom_range(0, 7))
      0:       wave = '0;
      1:       wave = '1;
      2:       wave = CFG_DATA_BITS'($urandom);
      default: wave = CFG_DATA_BITS'(last + $urandom_range(0, 12) - 6);
    endcase
    set_config(mode, first, last, stride, wave);
  endtask

  function automatic logic [PASS_PORT_BITS-1:0] pick_passes();
    case ($urandom_range(0, 15))
      0:       return PASS_PORT_BITS'($urandom);
      1:       return '1;
      2:       return PASS_PORT_BITS'($urandom_range(5, 300));
      default: return PASS_PORT_BITS'($urandom_range(0, 4));
    endcase
  endfunction

  // load aimed at or near a loop bound, mostly on the stride grid, then a walk across it
  task automatic loop_run();
    logic [POS_PORT_BITS-1:0] s25;
    logic [POS_PORT_BITS-1:0] spos;
    int k;
    s25 = POS_PORT_BITS'(stride_now);
    k   = $urandom_range(0, 10);
    case ($urandom_range(0, 3))
      0:       spos = POS_PORT_BITS'({1'b0, last_now} - k * s25);
      1:       spos = POS_PORT_BITS'({1'b0, first_now} + k * s25);
      2:       spos = POS_PORT_BITS'({1'b0, last_now} + k * s25);
      default: spos = POS_PORT_BITS'({1'b0, first_now} + $urandom_range(0, 40) - 20);
    endcase
    load(spos, 1'($urandom_range(0, 1)), pick_passes());
    repeat ($urandom_range(3, 24)) step_once();
  endtask

  task automatic noise_run();
    load(POS_PORT_BITS'($urandom), 1'($urandom_range(0, 1)), PASS_PORT_BITS'($urandom));
    repeat ($urandom_range(0, 5)) step_once();
  endtask

  initial begin
    int phase;
    int quota;
    int total;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset state and reset registers
    step_once();
    step_once();

    drain();
    set_config(LOOP_JUMP, 24'd0, 24'd4, 5'd1, 24'd3);
    load(25'd3, 1'b0, 24'd2);
    repeat (6) step_once();

    // ping-pong bouncing off both bounds
    drain();
    set_config(LOOP_PINGPONG, 24'd2, 24'd6, 5'd2, '1);
    load(25'd4, 1'b0, 24'd3);
    repeat (6) step_once();

    // spare mode code, widest stride, index wrap at both ends
    drain();
    set_config(LOOP_UNUSED, 24'hFFFFF0, '1, 5'd31, '0);
    load(25'h0FFFFFF, 1'b0, '1);
    repeat (2) step_once();
    load(25'h1000000, 1'b1, '0);
    repeat (2) step_once();

    // zero stride holds the index
    drain();
    set_config(LOOP_NONE, '0, '0, 5'd0, '1);
    load('1, 1'b1, 24'd1);
    repeat (2) step_once();

    total = sent + RANDOM_ITEMS;
    phase = 0;
    while (sent < total) begin
      drain();
      random_config();
      calm = (sent >= total - CALM_ITEMS);
      if (phase == 2) begin
        hold_req = 1'b1;
        load({1'b0, first_now}, 1'b0, pick_passes());
        repeat (60) send(OP_ADVANCE, POS_PORT_BITS'($urandom), 1'($urandom_range(0, 1)),
                         PASS_PORT_BITS'($urandom));
        drain();
      end
      quota = sent + PHASE_ITEMS;
      while (sent < quota) begin
        if ($urandom_range(0, 4) == 0) begin
          noise_run();
        end else begin
          loop_run();
        end
      end
      phase++;
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/lsag_pkg.sv
src/lsag_cfg.sv
src/lsag_core.sv
src/looping_sample_address_generator.sv
src/lsag_checker.sv
verif/lsag_checker.sv
verif/tb_looping_sample_address_generator.sv
